FILE: rtl/core/chash_pkg.sv
// Shared constants for the chained hash table: default geometry, field widths, request and status codes
package chash_pkg;

    // default table geometry
    localparam int BUCKETS_DEF = 8;
    localparam int NODES_DEF   = 64;

    // request and result field widths
    localparam int OP_W       = 2;
    localparam int KEY_W      = 31;
    localparam int GRADE_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int BUCKET_W   = 3;

    // request codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

endpackage

FILE: rtl/core/chained_hash_table.sv
// Keyed record table with separate chaining over a bounded node pool, top level
//
// One request at a time: a request is taken when start is high and busy is low,
// and its single result appears on the result ports for one cycle with done high.
// The receiver cannot hold a result off. A request passes through these steps: the
// key is multiplied by a reciprocal of BUCKETS as it is taken, the product is turned
// into the bucket index and the bucket head is read, the walk starts, each chain node
// costs one read of the node memory until the key is found or the chain ends, the
// outcome is decided and the result is carried out. An insert of a new key then scans
// the free map one 32-node word after another for the lowest free node and relinks
// the head; a remove that hits then frees the node. After reset the block clears its
// bucket heads and free map, one entry a cycle, and holds busy high meanwhile. Bucket
// heads and the free map share one memory and the records sit in a second; every
// access goes through their single read and write ports.
module chained_hash_table #(
    parameter int BUCKETS = chash_pkg::BUCKETS_DEF,
    parameter int NODES   = chash_pkg::NODES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [chash_pkg::OP_W-1:0]        op,
    input  logic [chash_pkg::KEY_W-1:0]       key,
    input  logic [chash_pkg::GRADE_W-1:0]     grade,
    output logic                              done,
    output logic [chash_pkg::STATUS_W-1:0]    status,
    output logic                              found,
    output logic [chash_pkg::GRADE_W-1:0]     grade_out,
    output logic [chash_pkg::BUCKET_W-1:0]    bucket
);

    // geometry
    localparam int PW   = $clog2(NODES + 1);
    localparam int NW   = $clog2(NODES);
    localparam int BW   = $clog2(BUCKETS);
    localparam int WW   = (NODES >= 32) ? 32 : (1 << $clog2(NODES));
    localparam int LW   = $clog2(WW);
    localparam int ROWS = (NODES + WW - 1) / WW;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW   = RW + LW;
    localparam int CD   = BUCKETS + ROWS;
    localparam int CA   = $clog2(CD);
    localparam int CW   = (PW > WW) ? PW : WW;
    localparam int KW   = chash_pkg::KEY_W;
    localparam int GW   = chash_pkg::GRADE_W;
    localparam int NDW  = KW + GW + PW;

    // reciprocal of the bucket count scaled by 2^(KW+BW), rounded up: exact quotient
    localparam int MW   = KW + 1;
    localparam int QSH  = KW + BW;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << QSH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_HASH   = 9'b000000100,
        S_HEAD   = 9'b000001000,
        S_WALK   = 9'b000010000,
        S_DECIDE = 9'b000100000,
        S_FREE   = 9'b001000000,
        S_LINK   = 9'b010000000,
        S_RM_WR  = 9'b100000000
    } state_t;

    // control registers
    state_t                          state_reg, state_next;
    logic [CA-1:0]                   clr_cnt_reg, clr_cnt_next;
    logic [RW-1:0]                   row_reg, row_next;
    logic                            done_reg, done_next;

    // request and walk registers
    logic [chash_pkg::OP_W-1:0]      op_reg, op_next;
    logic [KW-1:0]                   key_reg, key_next;
    logic [GW-1:0]                   grade_reg, grade_next;
    logic [BW-1:0]                   quo_reg, quo_next;
    logic [BW-1:0]                   rem_reg, rem_next;
    logic [PW-1:0]                   head_reg, head_next;
    logic [PW-1:0]                   cur_reg, cur_next;
    logic [PW-1:0]                   prev_reg, prev_next;
    logic [KW-1:0]                   prev_key_reg, prev_key_next;
    logic [GW-1:0]                   prev_grade_reg, prev_grade_next;
    logic [PW-1:0]                   hit_reg, hit_next;
    logic [PW-1:0]                   hit_link_reg, hit_link_next;
    logic [GW-1:0]                   hit_grade_reg, hit_grade_next;
    logic                            hit_found_reg, hit_found_next;
    logic [PW-1:0]                   slot_ptr_reg, slot_ptr_next;

    // result registers
    logic [chash_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                            found_reg, found_next;
    logic [GW-1:0]                   grade_out_reg, grade_out_next;

    // memory ports
    logic                            ctl_we;
    logic [CA-1:0]                   ctl_waddr, ctl_raddr;
    logic [CW-1:0]                   ctl_wdata, ctl_rdata_reg;
    logic                            node_we;
    logic [NW-1:0]                   node_waddr, node_raddr;
    logic [NDW-1:0]                  node_wdata, node_rdata_reg;
    logic [PW-1:0]                   rd_ptr, rd_ptr_m1;

    // memories: bucket heads then free map rows, and the record store
    logic [CW-1:0]                   ctl_mem [CD];
    logic [NDW-1:0]                  node_mem [NODES];

    // datapath helpers
    logic [KW+MW-1:0]                recip_prod;
    logic [BW-1:0]                   quo_mul;
    logic [BW-1:0]                   h_rem;
    logic [KW-1:0]                   nd_key;
    logic [GW-1:0]                   nd_grade;
    logic [PW-1:0]                   nd_link;
    logic [WW-1:0]                   row_bits, free_mask;
    logic [SW:0]                     map_idx;
    logic                            free_any;
    logic [LW-1:0]                   free_bit;
    logic [SW-1:0]                   slot_wide, hit_wide;
    logic [PW-1:0]                   hit_m1, prev_m1;
    logic [CA-1:0]                   bucket_addr;
    logic [BW+chash_pkg::BUCKET_W-1:0] bucket_ext;

    // ctl memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl_we)
        begin
            ctl_mem[ctl_waddr] <= ctl_wdata;
        end
        ctl_rdata_reg <= ctl_mem[ctl_raddr];
    end

    // node memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata_reg <= node_mem[node_raddr];
    end

    // key times reciprocal: only the low quotient bits matter for the remainder
    assign recip_prod = {{MW{1'b0}}, key} * {{KW{1'b0}}, RECIP};

    // remainder taken modulo 2^BW, exact since it is below the bucket count
    assign quo_mul = quo_reg * BW'(BUCKETS);
    assign h_rem   = key_reg[BW-1:0] - quo_mul;

    // node record fields
    assign nd_key   = node_rdata_reg[NDW-1 -: KW];
    assign nd_grade = node_rdata_reg[PW +: GW];
    assign nd_link  = node_rdata_reg[PW-1:0];

    // free map row: lowest free node, bits past the pool count as used
    always_comb
    begin
        row_bits  = ctl_rdata_reg[WW-1:0];
        free_mask = '0;
        map_idx   = '0;
        for (int b = 0; b < WW; b++)
        begin
            map_idx      = {1'b0, row_reg, LW'(b)};
            free_mask[b] = !row_bits[b] && (map_idx < (SW+1)'(NODES));
        end
        free_any = |free_mask;
        free_bit = '0;
        for (int b = WW - 1; b >= 0; b--)
        begin
            if (free_mask[b])
            begin
                free_bit = LW'(b);
            end
        end
    end

    // pointer and address arithmetic
    assign slot_wide   = {row_reg, free_bit};
    assign hit_m1      = hit_reg - PW'(1);
    assign prev_m1     = prev_reg - PW'(1);
    assign hit_wide    = SW'(hit_m1[NW-1:0]);
    assign rd_ptr_m1   = rd_ptr - PW'(1);
    assign node_raddr  = rd_ptr_m1[NW-1:0];
    assign bucket_addr = CA'(rem_reg);
    assign bucket_ext  = {{chash_pkg::BUCKET_W{1'b0}}, rem_reg};

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        row_next        = row_reg;
        done_next       = 1'b0;
        op_next         = op_reg;
        key_next        = key_reg;
        grade_next      = grade_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        head_next       = head_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_key_next   = prev_key_reg;
        prev_grade_next = prev_grade_reg;
        hit_next        = hit_reg;
        hit_link_next   = hit_link_reg;
        hit_grade_next  = hit_grade_reg;
        hit_found_next  = hit_found_reg;
        slot_ptr_next   = slot_ptr_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        grade_out_next  = grade_out_reg;
        ctl_we          = 1'b0;
        ctl_waddr       = bucket_addr;
        ctl_wdata       = '0;
        ctl_raddr       = bucket_addr;
        node_we         = 1'b0;
        node_waddr      = slot_wide[NW-1:0];
        node_wdata      = {key_reg, grade_reg, head_reg};
        rd_ptr          = cur_reg;

        unique case (state_reg)
            // zero bucket heads and free map after reset
            S_CLEAR:
            begin
                ctl_we    = 1'b1;
                ctl_waddr = clr_cnt_reg;
                if (clr_cnt_reg == CA'(CD - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CA'(1);
                end
            end

            // take a request and keep the low quotient bits of its key
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    key_next   = key;
                    grade_next = grade;
                    quo_next   = recip_prod[QSH +: BW];
                    state_next = S_HASH;
                end
            end

            // key modulo bucket count, then fetch the bucket head
            S_HASH:
            begin
                rem_next   = h_rem;
                ctl_raddr  = CA'(h_rem);
                state_next = S_HEAD;
            end

            // start the chain walk at the head
            S_HEAD:
            begin
                head_next      = ctl_rdata_reg[PW-1:0];
                cur_next       = ctl_rdata_reg[PW-1:0];
                prev_next      = '0;
                hit_found_next = 1'b0;
                rd_ptr         = ctl_rdata_reg[PW-1:0];
                if (ctl_rdata_reg[PW-1:0] == '0)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end

            // compare one node per cycle and follow its link
            S_WALK:
            begin
                if (nd_key == key_reg)
                begin
                    hit_next       = cur_reg;
                    hit_link_next  = nd_link;
                    hit_grade_next = nd_grade;
                    hit_found_next = 1'b1;
                    state_next     = S_DECIDE;
                end
                else
                begin
                    prev_next       = cur_reg;
                    prev_key_next   = nd_key;
                    prev_grade_next = nd_grade;
                    cur_next        = nd_link;
                    rd_ptr          = nd_link;
                    if (nd_link == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            // act on the walk outcome
            S_DECIDE:
            begin
                unique case (op_reg)
                    chash_pkg::OP_INSERT:
                    begin
                        if (hit_found_reg)
                        begin
                            done_next      = 1'b1;
                            status_next    = chash_pkg::ST_DUPLICATE;
                            found_next     = 1'b1;
                            grade_out_next = '0;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            row_next   = '0;
                            ctl_raddr  = CA'(BUCKETS);
                            state_next = S_FREE;
                        end
                    end
                    chash_pkg::OP_SEARCH:
                    begin
                        done_next      = 1'b1;
                        found_next     = hit_found_reg;
                        status_next    = hit_found_reg ? chash_pkg::ST_FOUND
                                                       : chash_pkg::ST_NOTFOUND;
                        grade_out_next = hit_found_reg ? hit_grade_reg : '0;
                        state_next     = S_IDLE;
                    end
                    chash_pkg::OP_REMOVE:
                    begin
                        if (hit_found_reg)
                        begin
                            // unlink at the head or in the predecessor
                            if (prev_reg == '0)
                            begin
                                ctl_we    = 1'b1;
                                ctl_waddr = bucket_addr;
                                ctl_wdata = CW'(hit_link_reg);
                            end
                            else
                            begin
                                node_we    = 1'b1;
                                node_waddr = prev_m1[NW-1:0];
                                node_wdata = {prev_key_reg, prev_grade_reg, hit_link_reg};
                            end
                            ctl_raddr  = CA'(BUCKETS) + CA'(hit_wide[SW-1:LW]);
                            state_next = S_RM_WR;
                        end
                        else
                        begin
                            done_next      = 1'b1;
                            status_next    = chash_pkg::ST_NOTFOUND;
                            found_next     = 1'b0;
                            grade_out_next = '0;
                            state_next     = S_IDLE;
                        end
                    end
                    default:
                    begin
                        done_next      = 1'b1;
                        status_next    = chash_pkg::ST_NOTFOUND;
                        found_next     = 1'b0;
                        grade_out_next = '0;
                        state_next     = S_IDLE;
                    end
                endcase
            end

            // scan the free map a row per cycle, claim the lowest free node or report the pool full
            S_FREE:
            begin
                if (free_any)
                begin
                    ctl_we        = 1'b1;
                    ctl_waddr     = CA'(BUCKETS) + CA'(row_reg);
                    ctl_wdata     = CW'(row_bits | (WW'(1) << free_bit));
                    node_we       = 1'b1;
                    node_waddr    = slot_wide[NW-1:0];
                    node_wdata    = {key_reg, grade_reg, head_reg};
                    slot_ptr_next = PW'(slot_wide[NW-1:0]) + PW'(1);
                    state_next    = S_LINK;
                end
                else if (row_reg == RW'(ROWS - 1))
                begin
                    done_next      = 1'b1;
                    status_next    = chash_pkg::ST_FULL;
                    found_next     = 1'b0;
                    grade_out_next = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    row_next  = row_reg + RW'(1);
                    ctl_raddr = CA'(BUCKETS) + CA'(row_reg + RW'(1));
                end
            end

            // new node becomes the bucket head
            S_LINK:
            begin
                ctl_we         = 1'b1;
                ctl_waddr      = bucket_addr;
                ctl_wdata      = CW'(slot_ptr_reg);
                done_next      = 1'b1;
                status_next    = chash_pkg::ST_INSERTED;
                found_next     = 1'b0;
                grade_out_next = '0;
                state_next     = S_IDLE;
            end

            // return the removed node to the pool
            S_RM_WR:
            begin
                ctl_we         = 1'b1;
                ctl_waddr      = CA'(BUCKETS) + CA'(hit_wide[SW-1:LW]);
                ctl_wdata      = CW'(ctl_rdata_reg[WW-1:0]
                                     & ~(WW'(1) << hit_wide[LW-1:0]));
                done_next      = 1'b1;
                status_next    = chash_pkg::ST_REMOVED;
                found_next     = 1'b1;
                grade_out_next = '0;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            row_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            row_reg     <= row_next;
            done_reg    <= done_next;
        end
    end

    // request, walk and result payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        grade_reg      <= grade_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        head_reg       <= head_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_key_reg   <= prev_key_next;
        prev_grade_reg <= prev_grade_next;
        hit_reg        <= hit_next;
        hit_link_reg   <= hit_link_next;
        hit_grade_reg  <= hit_grade_next;
        hit_found_reg  <= hit_found_next;
        slot_ptr_reg   <= slot_ptr_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        grade_out_reg  <= grade_out_next;
    end

    // outputs
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign grade_out = grade_out_reg;
    assign bucket    = bucket_ext[chash_pkg::BUCKET_W-1:0];

    // an accepted request goes straight to key reduction
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_HASH))
    else $error("accepted request did not enter key reduction");

    // a result never follows directly on another result
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
    else $error("two results in consecutive cycles");

    // found flag agrees with the status
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (found_reg == ((status_reg == chash_pkg::ST_DUPLICATE)
                                    || (status_reg == chash_pkg::ST_FOUND)
                                    || (status_reg == chash_pkg::ST_REMOVED))))
    else $error("found flag disagrees with status");

    // stored grade only reported on a successful search
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != chash_pkg::ST_FOUND)) |-> (grade_out_reg == '0))
    else $error("grade reported without a successful search");

    // the walk only ever reads a real node
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (cur_reg != '0))
    else $error("chain walk on an empty pointer");

endmodule

FILE: bench/chash_checker.sv
// Request and result monitor with a table predictor for the chained hash table
module chash_checker #(
    parameter int BUCKETS = chash_pkg::BUCKETS_DEF,
    parameter int NODES   = chash_pkg::NODES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [chash_pkg::OP_W-1:0]        op,
    input  logic [chash_pkg::KEY_W-1:0]       key,
    input  logic [chash_pkg::GRADE_W-1:0]     grade,
    input  logic                              done,
    input  logic [chash_pkg::STATUS_W-1:0]    status,
    input  logic                              found,
    input  logic [chash_pkg::GRADE_W-1:0]     grade_out,
    input  logic [chash_pkg::BUCKET_W-1:0]    bucket,
    output int                                mismatches,
    output int                                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import chash_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [GRADE_W-1:0]  grade_out;
        logic [BUCKET_W-1:0] bucket;
    } table_reply_t;

    // shadow copy of the table: chain links hold node index plus one, 0 ends a chain
    int unsigned        chain_head [BUCKETS];
    logic [KEY_W-1:0]   rec_key    [NODES];
    logic [GRADE_W-1:0] rec_grade  [NODES];
    int unsigned        rec_next   [NODES];
    bit                 rec_taken  [NODES];

    table_reply_t pending_replies[$];

    // apply one request to the shadow table and return the reply it should produce
    function automatic table_reply_t apply_request(input logic [OP_W-1:0] req_op,
                                                   input logic [KEY_W-1:0] req_key,
                                                   input logic [GRADE_W-1:0] req_grade);
        table_reply_t reply;
        int unsigned  b;
        int unsigned  cur;
        int unsigned  prev;
        int unsigned  hit;
        int unsigned  hit_prev;
        int unsigned  steps;
        int unsigned  slot;
        reply = '0;
        reply.status = ST_NOTFOUND;
        b = req_key % BUCKETS;
        reply.bucket = b[BUCKET_W-1:0];

        // bounded walk of the chain looking for the key
        cur = chain_head[b];
        prev = 0;
        hit = 0;
        hit_prev = 0;
        steps = 0;
        while (cur != 0 && cur <= NODES && steps < NODES && hit == 0)
        begin
            if (rec_key[cur-1] == req_key)
            begin
                hit = cur;
                hit_prev = prev;
            end
            else
            begin
                prev = cur;
                cur = rec_next[cur-1];
                steps++;
            end
        end

        case (req_op)
            OP_INSERT:
            begin
                if (hit != 0)
                begin
                    reply.status = ST_DUPLICATE;
                    reply.found = 1'b1;
                end
                else
                begin
                    // lowest free node wins
                    slot = NODES;
                    for (int i = NODES - 1; i >= 0; i--)
                        if (!rec_taken[i])
                            slot = i;
                    if (slot == NODES)
                        reply.status = ST_FULL;
                    else
                    begin
                        rec_taken[slot] = 1'b1;
                        rec_key[slot] = req_key;
                        rec_grade[slot] = req_grade;
                        rec_next[slot] = chain_head[b];
                        chain_head[b] = slot + 1;
                        reply.status = ST_INSERTED;
                    end
                end
            end
            OP_SEARCH:
            begin
                if (hit != 0)
                begin
                    reply.status = ST_FOUND;
                    reply.found = 1'b1;
                    reply.grade_out = rec_grade[hit-1];
                end
            end
            OP_REMOVE:
            begin
                if (hit != 0)
                begin
                    // unlink from head or from predecessor, then free the node
                    if (hit_prev == 0)
                        chain_head[b] = rec_next[hit-1];
                    else
                        rec_next[hit_prev-1] = rec_next[hit-1];
                    rec_taken[hit-1] = 1'b0;
                    reply.status = ST_REMOVED;
                    reply.found = 1'b1;
                end
            end
            default:
            begin
                // unused request code leaves the table alone
            end
        endcase
        return reply;
    endfunction

    // compare each result with the oldest prediction, then log any new request
    always @(posedge clk)
    begin : watch_channels
        table_reply_t got;
        table_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
                chain_head[i] = 0;
            for (int i = 0; i < NODES; i++)
            begin
                rec_key[i] = '0;
                rec_grade[i] = '0;
                rec_next[i] = 0;
                rec_taken[i] = 1'b0;
            end
            pending_replies.delete();
        end
        else
        begin
            if (done)
            begin
                got = {status, found, grade_out, bucket};
                if (pending_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected result: status %0d found %0d",
                                  " grade_out %0h bucket %0d"},
                                 status, found, grade_out, bucket);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.grade_out !== want.grade_out || got.bucket !== want.bucket)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected status %0d found %0d",
                                      " grade_out %0h bucket %0d, got status %0d",
                                      " found %0d grade_out %0h bucket %0d"},
                                     want.status, want.found, want.grade_out,
                                     want.bucket, got.status, got.found,
                                     got.grade_out, got.bucket);
                    end
                end
            end
            if (start && !busy)
                pending_replies.push_back(apply_request(op, key, grade));
        end
        outstanding <= pending_replies.size();
    end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the chained hash table: clock, reset, request stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import chash_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int POOL_KEYS    = 96;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 100;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    logic [GRADE_W-1:0]  grade;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [GRADE_W-1:0]  grade_out;
    logic [BUCKET_W-1:0] bucket;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;

    // keys reused across requests so that chains grow, collide and the pool fills
    logic [KEY_W-1:0] key_pool [POOL_KEYS];

    chained_hash_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .key       (key),
        .grade     (grade),
        .done      (done),
        .status    (status),
        .found     (found),
        .grade_out (grade_out),
        .bucket    (bucket)
    );

    chash_checker table_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .key         (key),
        .grade       (grade),
        .done        (done),
        .status      (status),
        .found       (found),
        .grade_out   (grade_out),
        .bucket      (bucket),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog on cycles with no request taken and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // present one request and hold it until the block takes it
    task automatic send_request(input logic [OP_W-1:0] req_op,
                                input logic [KEY_W-1:0] req_key,
                                input logic [GRADE_W-1:0] req_grade);
        @(negedge clk);
        start <= 1'b1;
        op <= req_op;
        key <= req_key;
        grade <= req_grade;
        do
            @(posedge clk);
        while (busy);
    endtask

    // random sender gap: mostly none, some short, a few long
    task automatic sender_gap();
        int roll;
        int len;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            len = 0;
        else if (roll < 90)
            len = $urandom_range(1, 16);
        else
            len = $urandom_range(17, 60);
        if (len > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (len - 1) @(negedge clk);
        end
    endtask

    // hold off until every predicted result has arrived
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [KEY_W-1:0] choose_key();
        logic [31:0] raw;
        raw = $urandom;
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_KEYS - 1)];
        return raw[KEY_W-1:0];
    endfunction

    function automatic logic [GRADE_W-1:0] choose_grade();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return '0;
        if (roll < 6)
            return '1;
        return GRADE_W'($urandom_range(0, 65535));
    endfunction

    // stimulus
    initial
    begin : stimulus
        logic [31:0]      raw;
        logic [2:0]       low_bits;
        logic [OP_W-1:0]  pick_op;
        int               roll;
        bit               fill;
        bit               steady;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_INSERT;
        key = '0;
        grade = '0;

        // distinct keys by index, about half of them piled onto one bucket
        for (int i = 0; i < POOL_KEYS; i++)
        begin
            raw = $urandom;
            low_bits = ($urandom_range(0, 1) == 1) ? 3'd5 : 3'($urandom_range(0, 7));
            key_pool[i] = {raw[20:0], 7'(i), low_bits};
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, duplicate, unused code, chain unlinking
        send_request(OP_SEARCH, 31'd0, 16'h0000);
        send_request(OP_INSERT, 31'd0, 16'h0000);
        send_request(OP_INSERT, 31'h7FFF_FFFF, 16'hFFFF);
        send_request(OP_INSERT, 31'd0, 16'h1234);
        send_request(OP_SEARCH, 31'd0, 16'hFFFF);
        send_request(OP_SEARCH, 31'h7FFF_FFFF, 16'h0000);
        send_request(OP_SEARCH, 31'd8, 16'h0000);
        send_request(OP_REMOVE, 31'd8, 16'h0000);
        send_request(OP_UNUSED, 31'd0, 16'hFFFF);
        send_request(OP_UNUSED, 31'h7FFF_FFFF, 16'hAAAA);
        send_request(OP_INSERT, 31'd8, 16'h5555);
        send_request(OP_INSERT, 31'd16, 16'hAAAA);
        send_request(OP_INSERT, 31'd24, 16'h00FF);
        send_request(OP_REMOVE, 31'd16, 16'h0000);
        send_request(OP_SEARCH, 31'd24, 16'h0000);
        send_request(OP_SEARCH, 31'd8, 16'h0000);
        send_request(OP_SEARCH, 31'd16, 16'h0000);
        send_request(OP_REMOVE, 31'd24, 16'h0000);
        send_request(OP_REMOVE, 31'd0, 16'h0000);
        send_request(OP_SEARCH, 31'd8, 16'h0000);
        send_request(OP_REMOVE, 31'h7FFF_FFFF, 16'h0000);
        send_request(OP_SEARCH, 31'h7FFF_FFFF, 16'h0000);
        wait_drained();

        // random phases: fill phases push the pool toward full, drain phases favour removes
        for (int phase = 0; phase < PHASES; phase++)
        begin
            fill = (phase % 2 == 0);
            steady = (phase % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (fill)
                    pick_op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_SEARCH :
                              (roll < 97) ? OP_REMOVE : OP_UNUSED;
                else
                    pick_op = (roll < 20) ? OP_INSERT : (roll < 50) ? OP_SEARCH :
                              (roll < 97) ? OP_REMOVE : OP_UNUSED;
                send_request(pick_op, choose_key(), choose_grade());
                if (!steady)
                    sender_gap();
            end
            wait_drained();
        end

        // verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
